/* hdl/psrp_pkg.sv */
// Shared definitions for the PC sampling region profiler.
// Holds the item mode codes, the sequencer states and the default region count.
// No dependencies.
package psrp_pkg;

  localparam int NUM_REGIONS_DEF = 32;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CNT
  } state_t;

endpackage

/* hdl/pc_sample_region_profiler.sv */
// PC sampling profiler with a per-region hit histogram.
// An in-range load or read goes through ST_CNT; an enabled sample scans the regions from
// slot 0 up (one bounds RAM read per region) to the first hit; other items answer at once.
// Throughput: one item at a time; the next item is taken in the cycle its predecessor's
// result is shown. Results cannot be stalled. Synchronous active-low reset clears the
// totals, the enable, the loaded flags and all hit counters at once (no clearing pass).
module pc_sample_region_profiler #(
  parameter int NUM_REGIONS = psrp_pkg::NUM_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [4:0]  in_region_index,
  input  logic [31:0] in_range_start,
  input  logic [31:0] in_range_end,
  input  logic [31:0] in_pc,
  output logic        out_valid,
  output logic        out_region_hit,
  output logic [4:0]  out_hit_index,
  output logic [31:0] out_region_count,
  output logic [31:0] out_sample_total,
  output logic [31:0] out_lost_total,
  output logic [31:0] out_last_lost_address
);

  import psrp_pkg::*;

  localparam int IW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  state_t state_r, state_nxt;

  logic                   cfg_en_r;
  logic [31:0]            pc_r, pc_nxt;
  logic [IW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   inc_r, inc_nxt;
  logic [31:0]            samples_r, samples_nxt;
  logic [31:0]            lost_r, lost_nxt;
  logic [31:0]            last_lost_r, last_lost_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [4:0]             out_idx_r, out_idx_nxt;
  logic [31:0]            out_cnt_r, out_cnt_nxt;

  logic [63:0]            bnd_mem [NUM_REGIONS];
  logic [63:0]            bnd_rd_r;
  logic [NUM_REGIONS-1:0] loaded_r;
  logic                   bnd_we;
  logic [IW-1:0]          bnd_raddr;

  logic [IW-1:0]          cnt_raddr;
  logic                   cnt_we;
  logic [31:0]            cnt_wdata;
  logic [31:0]            cnt_rdata;
  logic [IW-1:0]          cnt_addr_q;

  logic                   accept;
  logic                   idx_ok;
  logic [IW+4:0]          idx_wide;
  logic [IW-1:0]          idx_addr;
  logic [IW+4:0]          q_wide;
  logic                   cmp_hit;
  logic                   cmp_last;
  logic [31:0]            cnt_inc;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign idx_ok   = int'(in_region_index) < NUM_REGIONS;
  assign idx_wide = (IW + 5)'(in_region_index);
  assign idx_addr = idx_ok ? idx_wide[IW-1:0] : '0;
  assign q_wide   = (IW + 5)'(cnt_addr_q);
  assign cmp_hit  = loaded_r[cmp_idx_r] && (pc_r >= bnd_rd_r[31:0]) &&
                    (pc_r <= bnd_rd_r[63:32]);
  assign cmp_last = (cmp_idx_r == IW'(NUM_REGIONS - 1));
  assign cnt_inc  = cnt_rdata + 32'd1;

  psrp_cnt_store #(
    .NUM_REGIONS(NUM_REGIONS)
  ) u_cnt_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (cnt_raddr),
    .wr_en    (cnt_we),
    .wr_data  (cnt_wdata),
    .rd_data  (cnt_rdata),
    .rd_addr_q(cnt_addr_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode_t'(in_mode))
            MODE_LOAD, MODE_READ: begin
              if (idx_ok) state_nxt = ST_CNT;
            end
            MODE_SAMPLE: begin
              if (cfg_en_r) state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (cmp_hit) begin
          state_nxt = ST_CNT;
        end else if (cmp_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CNT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pc_nxt        = pc_r;
    cmp_idx_nxt   = cmp_idx_r;
    inc_nxt       = inc_r;
    samples_nxt   = samples_r;
    lost_nxt      = lost_r;
    last_lost_nxt = last_lost_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = 1'b0;
    out_idx_nxt   = 5'd0;
    out_cnt_nxt   = 32'd0;
    bnd_we        = 1'b0;
    bnd_raddr     = '0;
    cnt_raddr     = '0;
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_inc;
    case (state_r)
      ST_IDLE: begin
        cmp_idx_nxt = '0;
        cnt_raddr   = idx_addr;
        if (accept) begin
          pc_nxt = in_pc;
          case (mode_t'(in_mode))
            MODE_LOAD, MODE_READ: begin
              bnd_we  = idx_ok && (mode_t'(in_mode) == MODE_LOAD);
              inc_nxt = 1'b0;
              // slot out of range: answer at once with a zero count
              if (!idx_ok) begin
                out_valid_nxt = 1'b1;
                out_idx_nxt   = in_region_index;
              end
            end
            MODE_SAMPLE: begin
              inc_nxt = 1'b1;
              if (cfg_en_r) begin
                samples_nxt = samples_r + 32'd1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        cnt_raddr   = cmp_idx_r;
        bnd_raddr   = cmp_last ? '0 : cmp_idx_r + IW'(1);
        cmp_idx_nxt = cmp_idx_r + IW'(1);
        if (!cmp_hit && cmp_last) begin
          lost_nxt      = lost_r + 32'd1;
          last_lost_nxt = pc_r;
          out_valid_nxt = 1'b1;
        end
      end
      ST_CNT: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = q_wide[4:0];
        if (inc_r) begin
          cnt_we      = 1'b1;
          out_hit_nxt = 1'b1;
          out_cnt_nxt = cnt_inc;
        end else begin
          out_cnt_nxt = cnt_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // bounds RAM: {end, start} per region
  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[idx_addr] <= {in_range_end, in_range_start};
    end
    bnd_rd_r <= bnd_mem[bnd_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_en_r    <= 1'b0;
      loaded_r    <= '0;
      samples_r   <= 32'd0;
      lost_r      <= 32'd0;
      last_lost_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      samples_r   <= samples_nxt;
      lost_r      <= lost_nxt;
      last_lost_r <= last_lost_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_en_r <= cfg_wdata;
      end
      if (bnd_we) begin
        loaded_r[idx_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pc_r      <= pc_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    inc_r     <= inc_nxt;
    out_hit_r <= out_hit_nxt;
    out_idx_r <= out_idx_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_region_hit        = out_hit_r;
  assign out_hit_index         = out_idx_r;
  assign out_region_count      = out_cnt_r;
  // totals only move again after the next item is taken, so show them live
  assign out_sample_total      = samples_r;
  assign out_lost_total        = lost_r;
  assign out_last_lost_address = last_lost_r;

endmodule

/* hdl/psrp_cnt_store.sv */
// Hit counter store: one synchronous RAM of 32-bit counters plus one valid bit
// per entry, so reset clears every counter at once. Depends on nothing else.
module psrp_cnt_store #(
  parameter int NUM_REGIONS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [((NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1)-1:0] rd_addr,
  input  logic                                         wr_en,
  input  logic [31:0]                                  wr_data,
  output logic [31:0]                                  rd_data,
  output logic [((NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1)-1:0] rd_addr_q
);

  localparam int IW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  logic [31:0]            mem [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] vld_r;
  logic [31:0]            rd_r;
  logic                   rd_vld_r;
  logic [IW-1:0]          addr_q_r;
  logic                   fwd;

  // write back goes to the entry read in the previous cycle
  assign fwd = wr_en && (rd_addr == addr_q_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q_r] <= wr_data;
    end
    rd_r     <= fwd ? wr_data : mem[rd_addr];
    addr_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr_q_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr] | fwd;
    end
  end

  // an entry never written reads as zero
  assign rd_data   = rd_vld_r ? rd_r : 32'd0;
  assign rd_addr_q = addr_q_r;

endmodule

/* hdl/psrp_checker.sv */
// Port-level checks for the PC sampling profiler, bound to the top level.
// Depends on psrp_pkg and pc_sample_region_profiler.
module psrp_checker #(
  parameter int NUM_REGIONS = psrp_pkg::NUM_REGIONS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_mode,
  input logic [4:0]  in_region_index,
  input logic        out_valid,
  input logic        out_region_hit,
  input logic [4:0]  out_hit_index,
  input logic [31:0] out_region_count,
  input logic [31:0] out_lost_total
);

  import psrp_pkg::*;

  // a result always leaves the block ready for the next item
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // an in-range read passes through ST_CNT and then answers with its own slot
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_READ && int'(in_region_index) < NUM_REGIONS)
    |-> ##2 (out_valid && !out_region_hit && out_hit_index == $past(in_region_index, 2)))
    else $error("read result missing or wrong slot");

  // the lost total moves only with a miss result; skip the first cycle out of reset
  a_lost_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(out_lost_total)) |->
    (out_valid && !out_region_hit && out_hit_index == 5'd0 && out_region_count == 32'd0))
    else $error("lost total changed without a miss result");

  // a no-op item answers at once with zeros
  a_nop: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_NOP) |=>
    (out_valid && !out_region_hit && out_hit_index == 5'd0 && out_region_count == 32'd0))
    else $error("no-op result wrong");

endmodule

bind pc_sample_region_profiler psrp_checker #(.NUM_REGIONS(NUM_REGIONS)) u_psrp_checker (.*);

/* tb/sv/tb_pc_sample_region_profiler.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pc_sample_region_profiler: a directed table, then random
// load/sample/read/no-op items checked against an in-bench region histogram predictor.
// Depends on psrp_pkg and the profiler RTL only.
module tb_pc_sample_region_profiler;
  import psrp_pkg::*;

  localparam int NREG        = NUM_REGIONS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = NREG + 8;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  idx;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] pc;
  } prof_cmd_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  idx;
    logic [31:0] count;
    logic [31:0] total;
    logic [31:0] lost;
    logic [31:0] last_lost;
  } prof_rpt_t;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic      enable;
    prof_cmd_t cmd;
    logic      typed;
    prof_rpt_t rpt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [4:0]  in_region_index = '0;
  logic [31:0] in_range_start = '0;
  logic [31:0] in_range_end = '0;
  logic [31:0] in_pc = '0;
  logic        out_valid;
  logic        out_region_hit;
  logic [4:0]  out_hit_index;
  logic [31:0] out_region_count;
  logic [31:0] out_sample_total;
  logic [31:0] out_lost_total;
  logic [31:0] out_last_lost_address;

  // predictor copy of the profiler state
  logic [31:0] region_lo [NREG];
  logic [31:0] region_hi [NREG];
  bit          region_live [NREG];
  logic [31:0] region_hits [NREG];
  logic [31:0] samples_taken;
  logic [31:0] samples_lost;
  logic [31:0] lost_pc;
  bit          prof_on;

  prof_rpt_t reports_due [$];
  prof_rpt_t oldest_rpt;
  dir_row_t  dir_tab [$];

  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int n_load = 0, n_read = 0, n_nop = 0, n_sample = 0, n_off = 0, n_hit = 0, n_miss = 0;

  pc_sample_region_profiler DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .start                 (start),
    .busy                  (busy),
    .in_mode               (in_mode),
    .in_region_index       (in_region_index),
    .in_range_start        (in_range_start),
    .in_range_end          (in_range_end),
    .in_pc                 (in_pc),
    .out_valid             (out_valid),
    .out_region_hit        (out_region_hit),
    .out_hit_index         (out_hit_index),
    .out_region_count      (out_region_count),
    .out_sample_total      (out_sample_total),
    .out_lost_total        (out_lost_total),
    .out_last_lost_address (out_last_lost_address)
  );

  always #1 clk = ~clk;

  // Apply one item to the predicted histogram and return the report it produces.
  function automatic prof_rpt_t profile_item(input prof_cmd_t c);
    prof_rpt_t r;
    int        i;
    int        match;
    r = '0;
    match = -1;
    case (c.mode)
      MODE_LOAD: begin
        r.idx = c.idx;
        region_lo[c.idx]   = c.lo;
        region_hi[c.idx]   = c.hi;
        region_live[c.idx] = 1'b1;
        r.count = region_hits[c.idx];
      end
      MODE_SAMPLE: begin
        if (prof_on) begin
          samples_taken = samples_taken + 32'd1;
          // scan downward so the lowest matching slot wins
          for (i = NREG - 1; i >= 0; i--) begin
            if (region_live[i] && c.pc >= region_lo[i] && c.pc <= region_hi[i]) match = i;
          end
          if (match >= 0) begin
            region_hits[match] = region_hits[match] + 32'd1;
            r.hit   = 1'b1;
            r.idx   = 5'(match);
            r.count = region_hits[match];
          end else begin
            samples_lost = samples_lost + 32'd1;
            lost_pc      = c.pc;
          end
        end
      end
      MODE_READ: begin
        r.idx   = c.idx;
        r.count = region_hits[c.idx];
      end
      default: ;
    endcase
    r.total     = samples_taken;
    r.lost      = samples_lost;
    r.last_lost = lost_pc;
    return r;
  endfunction

  // Mostly samples aimed at loaded regions and their edges; loads favor compact regions.
  function automatic prof_cmd_t random_cmd();
    prof_cmd_t       c;
    int unsigned     sel;
    int unsigned     pick;
    int              slot;
    int              i;
    int              live [$];
    longint unsigned span;
    c.mode = MODE_SAMPLE;
    c.idx  = 5'($urandom);
    c.lo   = $urandom;
    c.hi   = $urandom;
    c.pc   = $urandom;
    sel = $urandom_range(99);
    if (sel < 18) begin
      c.mode = MODE_LOAD;
      pick = $urandom_range(19);
      if (pick < 16) begin
        c.hi = c.lo + 32'($urandom_range(4095));
      end else if (pick == 16) begin
        c.lo  = '0;
        c.idx = 5'($urandom_range(31, 24));
      end else if (pick == 17) begin
        c.hi  = '1;
        c.idx = 5'($urandom_range(31, 24));
      end else if (pick == 18) begin
        c.lo  = '0;
        c.hi  = '1;
        c.idx = 5'(NREG - 1);
      end
    end else if (sel < 26) begin
      c.mode = MODE_READ;
    end else if (sel < 30) begin
      c.mode = MODE_NOP;
    end else begin
      for (i = 0; i < NREG; i++) begin
        if (region_live[i] && region_lo[i] <= region_hi[i]) live.push_back(i);
      end
      pick = $urandom_range(99);
      if (live.size() != 0 && pick < 75) begin
        slot = live[$urandom_range(live.size() - 1)];
        if (pick < 55) begin
          span = {32'd0, region_hi[slot]} - {32'd0, region_lo[slot]} + 64'd1;
          c.pc = region_lo[slot] + 32'({$urandom, $urandom} % span);
        end else begin
          case (pick % 4)
            0: c.pc = region_lo[slot];
            1: c.pc = region_hi[slot];
            2: c.pc = region_lo[slot] - 32'd1;
            default: c.pc = region_hi[slot] + 32'd1;
          endcase
        end
      end
    end
    return c;
  endfunction

  task automatic tab_item(input mode_t m, input logic [4:0] idx, input logic [31:0] lo,
                          input logic [31:0] hi, input logic [31:0] pc,
                          input bit typed = 1'b0, input logic [4:0] want_idx = '0);
    dir_row_t row;
    row = '0;
    row.kind     = ROW_ITEM;
    row.cmd.mode = m;
    row.cmd.idx  = idx;
    row.cmd.lo   = lo;
    row.cmd.hi   = hi;
    row.cmd.pc   = pc;
    row.typed    = typed;
    row.rpt.idx  = want_idx;
    dir_tab.push_back(row);
  endtask

  task automatic tab_cfg(input logic en);
    dir_row_t row;
    row = '0;
    row.kind   = ROW_CFG;
    row.enable = en;
    dir_tab.push_back(row);
  endtask

  // Called at a rising edge. Leaves start high after acceptance; the next call or the
  // caller decides whether it drops.
  task automatic send_item(input prof_cmd_t c, input int idle_pct, input bit typed,
                           input prof_rpt_t typed_rpt);
    prof_rpt_t r;
    bit        was_on;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= c.mode;
    in_region_index <= c.idx;
    in_range_start  <= c.lo;
    in_range_end    <= c.hi;
    in_pc           <= c.pc;
    do @(posedge clk); while (busy);
    was_on = prof_on;
    r = profile_item(c);
    reports_due.push_back(typed ? typed_rpt : r);
    case (c.mode)
      MODE_LOAD: n_load++;
      MODE_READ: n_read++;
      MODE_SAMPLE: begin
        n_sample++;
        if (!was_on) n_off++;
        else if (r.hit) n_hit++;
        else n_miss++;
      end
      default: n_nop++;
    endcase
  endtask

  // Drain all outstanding items before touching the enable.
  task automatic write_enable(input logic en);
    start <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we  <= 1'b0;
    prof_on = en;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (reports_due.size() == 0) begin
        $error("unexpected result: hit_index %0d region_count %0h", out_hit_index,
               out_region_count);
        errors++;
      end else begin
        oldest_rpt = reports_due.pop_front();
        check_field("region_hit", 32'(oldest_rpt.hit), 32'(out_region_hit));
        check_field("hit_index", 32'(oldest_rpt.idx), 32'(out_hit_index));
        check_field("region_count", oldest_rpt.count, out_region_count);
        check_field("sample_total", oldest_rpt.total, out_sample_total);
        check_field("lost_total", oldest_rpt.lost, out_lost_total);
        check_field("last_lost_address", oldest_rpt.last_lost, out_last_lost_address);
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               reports_due.size());
      $display("tb_pc_sample_region_profiler NOT OK");
      $finish;
    end
  end

  initial begin
    int phase_idle [4];
    bit phase_en [4];
    int phase_len [4];
    int p;
    phase_idle = '{25, 57, 57, 0};
    phase_en   = '{1'b1, 1'b0, 1'b1, 1'b1};
    phase_len  = '{550, 150, 300, 475};
    for (p = 0; p < NREG; p++) begin
      region_lo[p]   = '0;
      region_hi[p]   = '0;
      region_live[p] = 1'b0;
      region_hits[p] = '0;
    end
    samples_taken = '0;
    samples_lost  = '0;
    lost_pc       = '0;
    prof_on       = 1'b0;

    // reset state, disabled samples, no-ops and loads: all counters still zero
    tab_item(MODE_READ,   5'd0,  32'h0,     32'h0,     32'h0,         1'b1, 5'd0);
    tab_item(MODE_READ,   5'd31, '1,        '1,        '1,            1'b1, 5'd31);
    tab_item(MODE_SAMPLE, 5'd9,  32'h0,     32'h0,     32'h0,         1'b1, 5'd0);
    tab_item(MODE_SAMPLE, 5'd31, '1,        '1,        '1,            1'b1, 5'd0);
    tab_item(MODE_NOP,    5'd31, '1,        '1,        '1,            1'b1, 5'd0);
    tab_item(MODE_LOAD,   5'd0,  32'h100,   32'h1FF,   32'h0,         1'b1, 5'd0);
    tab_item(MODE_LOAD,   5'd31, 32'h0,     '1,        32'h0,         1'b1, 5'd31);
    tab_item(MODE_LOAD,   5'd1,  32'h300,   32'h200,   32'h0,         1'b1, 5'd1);
    tab_item(MODE_LOAD,   5'd2,  32'h1000,  32'h1000,  32'h0,         1'b1, 5'd2);
    tab_cfg(1'b1);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h100);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h1FF);
    tab_item(MODE_SAMPLE, 5'd1,  32'h0,     32'h0,     32'h250);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h1000);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h0);
    // shrink the top slot to one address; its counter must survive
    tab_item(MODE_LOAD,   5'd31, '1,        '1,        32'h0);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     '1);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h8000_0000);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h0);
    tab_item(MODE_READ,   5'd31, 32'h0,     32'h0,     32'h0);
    tab_item(MODE_NOP,    5'd5,  32'h0,     32'h0,     32'h1FF);
    // overlapping full-range slot: lower slot keeps priority
    tab_item(MODE_LOAD,   5'd30, 32'h0,     '1,        32'h0);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h180);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h1234_5678);
    tab_item(MODE_LOAD,   5'd30, '1,        32'h0,     32'h0);
    tab_cfg(1'b0);
    tab_item(MODE_SAMPLE, 5'd0,  32'h0,     32'h0,     32'h180);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        write_enable(dir_tab[k].enable);
      end else begin
        send_item(dir_tab[k].cmd, 25, dir_tab[k].typed, dir_tab[k].rpt);
      end
    end

    for (p = 0; p < 4; p++) begin
      write_enable(phase_en[p]);
      repeat (phase_len[p]) send_item(random_cmd(), phase_idle[p], 1'b0, '0);
    end

    start <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("items: %0d loads, %0d reads, %0d no-ops, %0d samples (%0d while disabled)",
             n_load, n_read, n_nop, n_sample, n_off);
    $display("samples counted: %0d region hits, %0d lost; %0d results compared, %0d errors",
             n_hit, n_miss, checked, errors);
    if (errors == 0) begin
      $display("tb_pc_sample_region_profiler OK");
    end else begin
      $display("tb_pc_sample_region_profiler NOT OK");
    end
    $finish;
  end

endmodule
